// ----- hw/rtl/enalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enalu_pkg
// Opcodes, constants and shared types of the expression node ALU.
// ----------------------------------------------------------------------------
package enalu_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned MaxShift = 63;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_SHL  = 5'd5,
    OP_SHR  = 5'd6,
    OP_AND  = 5'd7,
    OP_OR   = 5'd8,
    OP_XOR  = 5'd9,
    OP_EQ   = 5'd10,
    OP_NE   = 5'd11,
    OP_LT   = 5'd12,
    OP_GT   = 5'd13,
    OP_LE   = 5'd14,
    OP_GE   = 5'd15,
    OP_NEG  = 5'd16,
    OP_LNOT = 5'd17,
    OP_BNOT = 5'd18,
    OP_LAND = 5'd19,
    OP_LOR  = 5'd20
  } op_e;

  // Data that rides alongside the divider stages.
  typedef struct packed {
    logic [4:0]       op;
    logic [DataW-1:0] res;
    logic             na;
    logic             nb;
    logic             bzero;
  } side_t;

endpackage

// ----- hw/rtl/enalu_div_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enalu_div_pipe
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module enalu_div_pipe
  import enalu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic             valid_o,
  output logic [DataW-1:0] quot_o,
  output logic [DataW-1:0] rem_o
);

  logic [DataW-1:0] rem_q [DivSteps];
  logic [DataW-1:0] dvd_q [DivSteps];
  logic [DataW-1:0] dsr_q [DivSteps];
  logic             vld_q [DivSteps];
  logic [DataW-1:0] rem_d [DivSteps];
  logic [DataW-1:0] dvd_d [DivSteps];
  logic [DataW-1:0] dsr_d [DivSteps];
  logic             vld_d [DivSteps];

  // Each stage shifts in one dividend bit and tries one subtraction.
  always_comb begin
    logic [DataW-1:0] rem_in;
    logic [DataW-1:0] dvd_in;
    logic [DataW-1:0] dsr_in;
    logic [DataW:0]   trial;
    logic [DataW:0]   diff;
    for (int i = 0; i < DivSteps; i++) begin
      if (i == 0) begin
        rem_in   = '0;
        dvd_in   = dividend_i;
        dsr_in   = divisor_i;
        vld_d[i] = valid_i;
      end else begin
        rem_in   = rem_q[i-1];
        dvd_in   = dvd_q[i-1];
        dsr_in   = dsr_q[i-1];
        vld_d[i] = vld_q[i-1];
      end
      trial = {rem_in, dvd_in[DataW-1]};
      diff  = trial - {1'b0, dsr_in};
      if (!diff[DataW]) begin
        rem_d[i] = diff[DataW-1:0];
        dvd_d[i] = {dvd_in[DataW-2:0], 1'b1};
      end else begin
        rem_d[i] = trial[DataW-1:0];
        dvd_d[i] = {dvd_in[DataW-2:0], 1'b0};
      end
      dsr_d[i] = dsr_in;
    end
  end

  // Valid bits are cleared by reset; the data registers are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivSteps; i++) vld_q[i] <= 1'b0;
    end else if (en_i) begin
      for (int i = 0; i < DivSteps; i++) vld_q[i] <= vld_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < DivSteps; i++) begin
        rem_q[i] <= rem_d[i];
        dvd_q[i] <= dvd_d[i];
        dsr_q[i] <= dsr_d[i];
      end
    end
  end

  assign valid_o = vld_q[DivSteps-1];
  assign quot_o  = dvd_q[DivSteps-1];
  assign rem_o   = rem_q[DivSteps-1];

endmodule

// ----- hw/rtl/expression_node_alu_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_node_alu_top
// Pipelined 64-bit integer ALU for one expression node per word.
// ----------------------------------------------------------------------------
// The block accepts one word every cycle unless the output stalls. Each word
// passes one input stage that computes the simple operations and the
// multiplier partial products, 64 divider stages that each produce one
// quotient bit, and the output register. Every operation takes the same
// path, so results leave in order. The whole pipeline holds only when a
// finished word waits at the output and the consumer is not ready.
module expression_node_alu_top
  import enalu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [4:0]              op_i,
  input  logic signed [DataW-1:0] left_operand_i,
  input  logic signed [DataW-1:0] right_operand_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] result_o,
  output logic                    div_by_zero_o
);

  localparam int unsigned HalfW = DataW / 2;

  logic en;

  // Input stage registers.
  logic             v0_q;
  logic [4:0]       op0_q;
  logic [DataW-1:0] simple0_q;
  logic [DataW-1:0] pll0_q;
  logic [HalfW-1:0] plh0_q;
  logic [HalfW-1:0] phl0_q;
  logic             na0_q, nb0_q, bz0_q;
  logic [DataW-1:0] ma0_q, mb0_q;

  logic [DataW-1:0] simple_d;
  logic [DataW-1:0] a_u, b_u;
  logic [DataW-1:0] pll_d;
  logic [HalfW-1:0] plh_d, phl_d;

  side_t side_d;
  side_t side_q [DivSteps];

  logic             dv_valid;
  logic [DataW-1:0] dv_quot, dv_rem;

  logic             out_valid_q;
  logic [DataW-1:0] result_q;
  logic             dz_q;
  logic [DataW-1:0] result_d;
  logic             dz_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign a_u        = left_operand_i;
  assign b_u        = right_operand_i;

  // Operations that need no more than one wide add or compare.
  always_comb begin
    simple_d = '0;
    case (op_i)
      OP_ADD:  simple_d = a_u + b_u;
      OP_SUB:  simple_d = a_u - b_u;
      OP_SHL:  simple_d = (b_u > DataW'(MaxShift)) ? '0 : (a_u << b_u[5:0]);
      OP_SHR:  simple_d = (b_u > DataW'(MaxShift)) ? '0 : (a_u >> b_u[5:0]);
      OP_AND:  simple_d = a_u & b_u;
      OP_OR:   simple_d = a_u | b_u;
      OP_XOR:  simple_d = a_u ^ b_u;
      OP_EQ:   simple_d = DataW'(a_u == b_u);
      OP_NE:   simple_d = DataW'(a_u != b_u);
      OP_LT:   simple_d = DataW'(left_operand_i < right_operand_i);
      OP_GT:   simple_d = DataW'(left_operand_i > right_operand_i);
      OP_LE:   simple_d = DataW'(left_operand_i <= right_operand_i);
      OP_GE:   simple_d = DataW'(left_operand_i >= right_operand_i);
      OP_NEG:  simple_d = '0 - a_u;
      OP_LNOT: simple_d = DataW'(a_u == '0);
      OP_BNOT: simple_d = ~a_u;
      OP_LAND: simple_d = DataW'((a_u != '0) && (b_u != '0));
      OP_LOR:  simple_d = DataW'((a_u != '0) || (b_u != '0));
      default: simple_d = '0;
    endcase
  end

  // Partial products of the low 64 bits of the product.
  assign pll_d = {{HalfW{1'b0}}, a_u[HalfW-1:0]} * {{HalfW{1'b0}}, b_u[HalfW-1:0]};
  assign plh_d = a_u[HalfW-1:0] * b_u[DataW-1:HalfW];
  assign phl_d = a_u[DataW-1:HalfW] * b_u[HalfW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q     <= op_i;
      simple0_q <= simple_d;
      pll0_q    <= pll_d;
      plh0_q    <= plh_d;
      phl0_q    <= phl_d;
      na0_q     <= a_u[DataW-1];
      nb0_q     <= b_u[DataW-1];
      bz0_q     <= (b_u == '0);
      ma0_q     <= a_u[DataW-1] ? ('0 - a_u) : a_u;
      mb0_q     <= b_u[DataW-1] ? ('0 - b_u) : b_u;
    end
  end

  // The product is summed as the word enters the side line.
  always_comb begin
    side_d.op    = op0_q;
    side_d.res   = simple0_q;
    side_d.na    = na0_q;
    side_d.nb    = nb0_q;
    side_d.bzero = bz0_q;
    if (op0_q == OP_MUL) begin
      side_d.res = pll0_q + {plh0_q + phl0_q, {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DivSteps; i++) side_q[i] <= side_q[i-1];
    end
  end

  enalu_div_pipe u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v0_q),
    .dividend_i (ma0_q),
    .divisor_i  (mb0_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  // Sign correction and the zero divisor case.
  always_comb begin
    result_d = side_q[DivSteps-1].res;
    dz_d     = 1'b0;
    if (side_q[DivSteps-1].op == OP_DIV || side_q[DivSteps-1].op == OP_MOD) begin
      if (side_q[DivSteps-1].bzero) begin
        result_d = '0;
        dz_d     = 1'b1;
      end else if (side_q[DivSteps-1].op == OP_DIV) begin
        result_d = (side_q[DivSteps-1].na ^ side_q[DivSteps-1].nb) ? ('0 - dv_quot) : dv_quot;
      end else begin
        result_d = side_q[DivSteps-1].na ? ('0 - dv_rem) : dv_rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      dz_q     <= dz_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign div_by_zero_o = dz_q;

`ifndef SYNTHESIS
  // A zero divisor always comes with a zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_by_zero_o) |-> (result_o == '0))
    else $error("div_by_zero set with non-zero result");

  // A stalled output word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_o)
      && $stable(div_by_zero_o)))
    else $error("output word changed while stalled");

  // The input side is held only when the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input held without an output stall");
`endif

endmodule
